### rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types, codes and sizes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int ADDR_W    = $clog2(NUM_PAGES);
    localparam int PAGE_W    = 16;
    localparam int TOP_W     = 17;
    localparam int COUNT_W   = 17;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE   = 1'd1;

    localparam logic [TOP_W-1:0] NUM_PAGES_BOUND = TOP_W'(NUM_PAGES);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STS_ALLOCATED = 3'd0,
        STS_FREED     = 3'd1,
        STS_DOUBLE    = 3'd2,
        STS_BAD_ADDR  = 3'd3,
        STS_OOM       = 3'd4
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [PAGE_W-1:0] page_index;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_index_res;
        t_status            status;
        logic [COUNT_W-1:0] free_count;
    } t_out_item;

    // One entry of the page memory: the free flag and the list link.
    typedef struct packed {
        logic              is_free;
        logic [PAGE_W-1:0] link;
    } t_page_entry;

    localparam int ENTRY_W = $bits(t_page_entry);

endpackage

### rtl/pfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/page_frame_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator
// Allocates and frees page frames over a last-in-first-out free list.
// ----------------------------------------------------------------------------
// The page memory, which holds the free flag and the list link of every page,
// is read in the cycle the request is accepted and written back, where the list
// changes, in the execute state once any stalled result has left the output
// register; the next request is accepted after that write. After reset the block
// sweeps the page memory once, one entry per cycle; input is stalled during the
// sweep while configuration writes are still taken. A finished result waits in an
// output register, so a new request may be accepted while it is stalled.
module page_frame_allocator_unit
    import pfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]  r_first_page;
    logic [TOP_W-1:0]   r_top_page;
    logic [PAGE_W-1:0]  r_head, n_head;
    logic               r_empty, n_empty;
    logic [COUNT_W-1:0] r_count, n_count;
    t_in_item           r_req;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               in_accept;
    logic               exec_go;
    logic               range_bad;
    logic [TOP_W-1:0]   bound;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_wr_addr;
    t_page_entry        ram_wr_data;
    logic [ADDR_W-1:0]  ram_rd_addr;
    t_page_entry        ram_rd_data;

    pfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PAGES)
    ) u_page_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign exec_go     = (r_state == S_EXEC) && !(r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign ram_rd_addr = (i_in_item.kind == KIND_FREE) ?
                         i_in_item.page_index[ADDR_W-1:0] : r_head[ADDR_W-1:0];

    always_comb begin
        if ((r_top_page == '0) || (r_top_page > NUM_PAGES_BOUND)) begin
            bound = NUM_PAGES_BOUND;
        end else begin
            bound = r_top_page;
        end
        range_bad = (r_req.page_index < r_first_page) ||
                    ({1'b0, r_req.page_index} >= bound);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_empty     = r_empty;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_wr_addr = r_clr_addr;
        ram_wr_data = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_req.kind == KIND_FREE) begin
                        n_out_item.page_index_res = r_req.page_index;
                        if (range_bad) begin
                            n_out_item.status = STS_BAD_ADDR;
                        end else if (ram_rd_data.is_free) begin
                            n_out_item.status = STS_DOUBLE;
                        end else begin
                            n_out_item.status   = STS_FREED;
                            ram_we              = 1'b1;
                            ram_wr_addr         = r_req.page_index[ADDR_W-1:0];
                            ram_wr_data.is_free = 1'b1;
                            ram_wr_data.link    = r_head;
                            n_head              = r_req.page_index;
                            n_empty             = 1'b0;
                            if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end else begin
                        if (r_empty) begin
                            n_out_item.page_index_res = '0;
                            n_out_item.status         = STS_OOM;
                        end else begin
                            n_out_item.page_index_res = r_head;
                            n_out_item.status         = STS_ALLOCATED;
                            ram_we                    = 1'b1;
                            ram_wr_addr               = r_head[ADDR_W-1:0];
                            ram_wr_data.is_free       = 1'b0;
                            ram_wr_data.link          = ram_rd_data.link;
                            n_head                    = ram_rd_data.link;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                            if (n_count == '0) begin
                                n_empty = 1'b1;
                                n_head  = '0;
                            end
                        end
                    end
                    n_out_item.free_count = n_count;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_first_page <= '0;
            r_top_page   <= NUM_PAGES_BOUND;
            r_head       <= '0;
            r_empty      <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                    CFG_TOP_PAGE:   r_top_page   <= i_cfg_data[TOP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_item;
        end
        r_out_item <= n_out_item;
    end

endmodule

### rtl/pfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_item
);

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // The memory sweep keeps the input stalled right after reset.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // Only one transaction is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // A result is waiting at the output once an accepted request has reached the execute state.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ##1 o_out_valid)
        else $error("no result after accepted request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= STS_OOM))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate and free transactions into the page frame allocator under
// several range settings. A directed table covers the list extremes, range
// errors, double frees and running out of memory. Random bursts of frees and
// allocations follow. Every result is checked against its expected value in the
// table or against a predictor of the free list that runs alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import pfa_pkg::*;

    typedef enum logic [1:0] {
        PG_UNKNOWN = 2'd0,
        PG_FREE    = 2'd1,
        PG_ALLOC   = 2'd2
    } t_pg_sts;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_in_item              req;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        bit                    typed;
        t_out_item             res;
    } t_row;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    t_pg_sts              pg_sts [NUM_PAGES];
    logic [PAGE_W-1:0]    page_link [NUM_PAGES];
    logic [PAGE_W-1:0]    head_page;
    logic                 list_is_empty;
    logic [COUNT_W-1:0]   free_pages;
    logic [PAGE_W-1:0]    range_first;
    logic [TOP_W-1:0]     range_top;

    t_out_item            pending_results [$];
    t_row                 dir_rows [$];
    int                   err_cnt = 0;
    bit                   idle_on = 1'b1;

    page_frame_allocator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("[page_frame_allocator_unit] ERROR");
        $finish;
    end

    function automatic int range_bound();
        int b;
        b = (range_top == '0) ? NUM_PAGES : int'(range_top);
        if (b > NUM_PAGES) begin
            b = NUM_PAGES;
        end
        return b;
    endfunction

    function automatic t_out_item predict_request(input t_in_item req);
        t_out_item res;
        res = '0;
        if (req.kind == KIND_FREE) begin
            res.page_index_res = req.page_index;
            if (req.page_index < range_first || int'(req.page_index) >= range_bound()) begin
                res.status = STS_BAD_ADDR;
            end else if (pg_sts[req.page_index] == PG_FREE) begin
                res.status = STS_DOUBLE;
            end else begin
                pg_sts[req.page_index]    = PG_FREE;
                page_link[req.page_index] = head_page;
                head_page     = req.page_index;
                list_is_empty = 1'b0;
                if (free_pages != '1) begin
                    free_pages = free_pages + 1'b1;
                end
                res.status = STS_FREED;
            end
        end else if (list_is_empty) begin
            res.status = STS_OOM;
        end else begin
            res.page_index_res = head_page;
            pg_sts[head_page]  = PG_ALLOC;
            head_page = page_link[head_page];
            if (free_pages != '0) begin
                free_pages = free_pages - 1'b1;
            end
            if (free_pages == '0) begin
                list_is_empty = 1'b1;
                head_page     = '0;
            end
            res.status = STS_ALLOCATED;
        end
        res.free_count = free_pages;
        return res;
    endfunction

    task automatic issue_request(input t_in_item req, input bit typed, input t_out_item res);
        t_out_item predicted;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        predicted = predict_request(req);
        pending_results.push_back(typed ? res : predicted);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_FIRST_PAGE) begin
            range_first = data[PAGE_W-1:0];
        end else begin
            range_top = data[TOP_W-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_req(input t_kind k, input logic [PAGE_W-1:0] page, input bit typed,
                           input logic [PAGE_W-1:0] r_page, input t_status r_sts,
                           input logic [COUNT_W-1:0] r_cnt);
        t_row row;
        row.kind                 = ROW_REQ;
        row.req.kind             = k;
        row.req.page_index       = page;
        row.idx                  = CFG_FIRST_PAGE;
        row.data                 = '0;
        row.typed                = typed;
        row.res.page_index_res   = r_page;
        row.res.status           = r_sts;
        row.res.free_count       = r_cnt;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_row row;
        row.kind  = ROW_CFG;
        row.req   = '0;
        row.idx   = idx;
        row.data  = data;
        row.typed = 1'b0;
        row.res   = '0;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, out_item);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.page_index_res !== want.page_index_res) begin
                    $display("%0t page_index_res: expected %h, actual %h", $time,
                             want.page_index_res, out_item.page_index_res);
                    err_cnt++;
                end
                if (out_item.status !== want.status) begin
                    $display("%0t status: expected %0d, actual %0d", $time,
                             want.status, out_item.status);
                    err_cnt++;
                end
                if (out_item.free_count !== want.free_count) begin
                    $display("%0t free_count: expected %0d, actual %0d", $time,
                             want.free_count, out_item.free_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : out_stall_gen
        int n;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 31) == 0) begin
                repeat ($urandom_range(32, 96)) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_in_item req;
        int lo;
        int top;
        int bound;
        int span;
        int base;
        int sent;
        int burst;
        int pick;
        int page;
        bit free_burst;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        for (int i = 0; i < NUM_PAGES; i++) begin
            pg_sts[i]    = PG_UNKNOWN;
            page_link[i] = '0;
        end
        head_page     = '0;
        list_is_empty = 1'b1;
        free_pages    = '0;
        range_first   = '0;
        range_top     = NUM_PAGES_BOUND;

        add_req(KIND_ALLOC, 16'h0000, 1, 16'h0000, STS_OOM,       17'd0);
        add_req(KIND_FREE,  16'h0000, 1, 16'h0000, STS_FREED,     17'd1);
        add_req(KIND_FREE,  16'h0000, 1, 16'h0000, STS_DOUBLE,    17'd1);
        add_req(KIND_FREE,  16'hFFFF, 1, 16'hFFFF, STS_FREED,     17'd2);
        add_req(KIND_ALLOC, 16'h1234, 1, 16'hFFFF, STS_ALLOCATED, 17'd1);
        add_req(KIND_ALLOC, 16'hFFFF, 1, 16'h0000, STS_ALLOCATED, 17'd0);
        add_req(KIND_ALLOC, 16'h0000, 1, 16'h0000, STS_OOM,       17'd0);
        add_req(KIND_FREE,  16'h0000, 1, 16'h0000, STS_FREED,     17'd1);
        add_cfg(CFG_FIRST_PAGE, 17'h00100);
        add_cfg(CFG_TOP_PAGE,   17'h00200);
        add_req(KIND_FREE,  16'h00FF, 1, 16'h00FF, STS_BAD_ADDR,  17'd1);
        add_req(KIND_FREE,  16'h0100, 0, 16'h0000, STS_ALLOCATED, 17'd0);
        add_req(KIND_FREE,  16'h01FF, 0, 16'h0000, STS_ALLOCATED, 17'd0);
        add_req(KIND_FREE,  16'h0200, 1, 16'h0200, STS_BAD_ADDR,  17'd3);
        add_req(KIND_FREE,  16'hFFFF, 1, 16'hFFFF, STS_BAD_ADDR,  17'd3);
        add_cfg(CFG_TOP_PAGE,   17'h00000);
        add_req(KIND_FREE,  16'hFFFF, 0, 16'h0000, STS_ALLOCATED, 17'd0);
        add_req(KIND_FREE,  16'h0200, 0, 16'h0000, STS_ALLOCATED, 17'd0);
        add_cfg(CFG_TOP_PAGE,   17'h1FFFF);
        add_cfg(CFG_FIRST_PAGE, 17'h0FFFF);
        add_req(KIND_FREE,  16'hFFFE, 1, 16'hFFFE, STS_BAD_ADDR,  17'd5);
        add_req(KIND_FREE,  16'hFFFF, 1, 16'hFFFF, STS_DOUBLE,    17'd5);
        add_cfg(CFG_FIRST_PAGE, 17'h00000);
        add_cfg(CFG_TOP_PAGE,   17'h00001);
        add_req(KIND_FREE,  16'h0001, 1, 16'h0001, STS_BAD_ADDR,  17'd5);
        add_req(KIND_FREE,  16'h0000, 1, 16'h0000, STS_DOUBLE,    17'd5);
        add_cfg(CFG_TOP_PAGE,   17'h10000);
        repeat (5) add_req(KIND_ALLOC, 16'h5A5A, 0, 16'h0000, STS_ALLOCATED, 17'd0);
        add_req(KIND_ALLOC, 16'hA5A5, 1, 16'h0000, STS_OOM,       17'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                stop_input();
                write_register(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    lo  = 0;
                    top = NUM_PAGES;
                end
                1: begin
                    lo  = $urandom_range(0, 60000);
                    top = lo + $urandom_range(16, 64);
                end
                2: begin
                    lo  = $urandom_range(0, 1000);
                    top = 0;
                end
                3: begin
                    lo  = $urandom_range(30000, 65000);
                    top = $urandom_range(NUM_PAGES + 1, 131071);
                end
                4: begin
                    lo  = $urandom_range(0, NUM_PAGES - 2);
                    top = lo + 1;
                end
                default: begin
                    lo  = 65500;
                    top = NUM_PAGES;
                end
            endcase
            stop_input();
            write_register(CFG_FIRST_PAGE, CFG_W'(lo));
            write_register(CFG_TOP_PAGE, CFG_W'(top));
            idle_on = (ph != 5);
            bound = range_bound();
            span  = (bound - lo > 48) ? 48 : bound - lo;
            base  = lo + $urandom_range(0, bound - lo - span);
            sent  = 0;
            while (sent < 70) begin
                free_burst = ($urandom_range(0, 99) < 55);
                burst      = $urandom_range(1, 8);
                repeat (burst) begin
                    pick = $urandom_range(0, 9);
                    if (!free_burst || pick == 0) begin
                        page = $urandom_range(0, NUM_PAGES - 1);
                    end else if (pick == 1 && lo > 0) begin
                        page = lo - 1;
                    end else if (pick == 2 && bound < NUM_PAGES) begin
                        page = bound;
                    end else begin
                        page = base + $urandom_range(0, span - 1);
                    end
                    req.kind       = free_burst ? KIND_FREE : KIND_ALLOC;
                    req.page_index = PAGE_W'(page);
                    issue_request(req, 1'b0, '0);
                    sent++;
                end
            end
        end

        stop_input();
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (err_cnt == 0) begin
            $display("[page_frame_allocator_unit] OK");
        end else begin
            $display("[page_frame_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
